>>> rtl/arp_cache_resolver_assert.svh
// Assertion macros for the checker file.
// Depends on nothing; included by the checker module only.
`ifndef ARP_CACHE_RESOLVER_ASSERT_SVH
`define ARP_CACHE_RESOLVER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define ACR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ACR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/acr_pkg.sv
// Shared constants and types of the address-resolution cache.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package acr_pkg;
    localparam int Entries = 8;
    localparam int IdxW    = $clog2(Entries);
    localparam int CntW    = $clog2(Entries + 1);

    typedef enum logic [1:0] {
        CMD_LEARN   = 2'd0,
        CMD_RESOLVE = 2'd1,
        CMD_GATEWAY = 2'd2,
        CMD_TICK    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_LEARNED = 3'd0,
        KIND_HIT     = 3'd1,
        KIND_MISS    = 3'd2,
        KIND_REQUEST = 3'd3,
        KIND_GW_ADD  = 3'd4,
        KIND_GW_FULL = 3'd5
    } t_kind;

    localparam logic [1:0] REG_LOCAL_IP = 2'd0;
    localparam logic [1:0] REG_NET_MASK = 2'd1;
    localparam logic [1:0] REG_LIFETIME = 2'd2;
    localparam logic [1:0] REG_HOLDOFF  = 2'd3;

    // One queued command between the front and back parts.
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] ip;
        logic [47:0] hw;
    } t_item;
endpackage

>>> rtl/acr_front.sv
// Front part: input transfer, register file and a two-deep command queue.
// Depends on acr_pkg.
`timescale 1ns / 1ps
module acr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic [31:0]        i_target_ip,
    input  logic [47:0]        i_hw_addr,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic [31:0]        o_local_ip,
    output logic [31:0]        o_net_mask,
    output logic [23:0]        o_lifetime,
    output logic [15:0]        o_holdoff,
    output acr_pkg::t_item     o_item,
    output logic               o_item_valid,
    input  logic               i_item_pop
);
    import acr_pkg::*;

    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic [31:0] r_local_ip, r_net_mask;
    logic [23:0] r_lifetime;
    logic [15:0] r_holdoff;
    logic        push, pop;

    assign o_ready      = (r_cnt != 2'd2);
    assign o_cfg_ready  = 1'b1;
    assign push         = i_valid && o_ready;
    assign pop          = i_item_pop && (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_local_ip   = r_local_ip;
    assign o_net_mask   = r_net_mask;
    assign o_lifetime   = r_lifetime;
    assign o_holdoff    = r_holdoff;

    // Queue payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{cmd: t_cmd'(i_command), ip: i_target_ip, hw: i_hw_addr};
        end
    end

    // Queue pointers and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= 1'b0;
            r_rp       <= 1'b0;
            r_cnt      <= 2'd0;
            r_local_ip <= 32'd0;
            r_net_mask <= 32'hFFFF_FF00;
            r_lifetime <= 24'd16384;
            r_holdoff  <= 16'd18;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_LOCAL_IP: r_local_ip <= i_cfg_data;
                    REG_NET_MASK: r_net_mask <= i_cfg_data;
                    REG_LIFETIME: r_lifetime <= i_cfg_data[23:0];
                    REG_HOLDOFF:  r_holdoff  <= i_cfg_data[15:0];
                    default:      r_holdoff  <= r_holdoff;
                endcase
            end
        end
    end
endmodule

>>> rtl/acr_back.sv
// Back part: cache store and sequencer that scans entries and emits results.
// Depends on acr_pkg.
`timescale 1ns / 1ps
module acr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  acr_pkg::t_item i_item,
    input  logic           i_item_valid,
    output logic           o_item_pop,
    input  logic [31:0]    i_local_ip,
    input  logic [31:0]    i_net_mask,
    input  logic [23:0]    i_lifetime,
    input  logic [15:0]    i_holdoff,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_kind,
    output logic [4:0]     o_entry_index,
    output logic [47:0]    o_hw_out,
    output logic [31:0]    o_request_ip,
    output logic           o_last
);
    import acr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DECIDE, ST_GWREQ, ST_FINAL, ST_OUT
    } t_state;

    t_state            r_state, r_ret;
    logic [31:0]       r_ip [Entries];
    logic [47:0]       r_hw [Entries];
    logic [31:0]       r_stamp [Entries];
    logic [Entries-1:0] r_gw, r_vld;
    logic [31:0]       r_tick, r_next_req;
    t_item             r_cur;
    logic [CntW-1:0]   r_i;
    logic              r_found, r_cand_ok, r_any;
    logic [IdxW-1:0]   r_fidx, r_cand;
    logic              r_needgate;
    logic [2:0]        r_kind;
    logic [4:0]        r_oidx;
    logic [47:0]       r_ohw;
    logic [31:0]       r_orip;
    logic              r_olast;

    logic [IdxW-1:0]   ci;
    logic              fresh_c;
    logic              gate_c;
    logic [32:0]       hold_sum;

    assign ci       = r_i[IdxW-1:0];
    assign fresh_c  = r_vld[ci] &&
        ({1'b0, r_stamp[ci]} + {9'd0, i_lifetime} > {1'b0, r_tick});
    assign gate_c   = ((i_item.ip ^ i_local_ip) & i_net_mask) != 32'd0;
    assign hold_sum = {1'b0, r_tick} + {17'd0, i_holdoff};

    assign o_item_pop    = (r_state == ST_IDLE) && i_item_valid;
    assign o_valid       = (r_state == ST_OUT);
    assign o_kind        = r_kind;
    assign o_entry_index = r_oidx;
    assign o_hw_out      = r_ohw;
    assign o_request_ip  = r_orip;
    assign o_last        = r_olast;

    // Sequencer: one entry examined per cycle while no result waits in ST_OUT; results leave through r_o*.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ret      <= ST_IDLE;
            r_gw       <= '0;
            r_vld      <= '0;
            r_tick     <= 32'd0;
            r_next_req <= 32'd0;
            for (int k = 0; k < Entries; k++) begin
                r_ip[k]    <= 32'd0;
                r_hw[k]    <= 48'd0;
                r_stamp[k] <= 32'd0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_cur      <= i_item;
                        r_found    <= 1'b0;
                        r_cand_ok  <= 1'b0;
                        r_cand     <= '0;
                        r_any      <= 1'b0;
                        r_needgate <= gate_c;
                        unique case (i_item.cmd)
                            CMD_TICK: begin
                                if (r_tick != 32'hFFFF_FFFF) r_tick <= r_tick + 32'd1;
                            end
                            CMD_GATEWAY: begin
                                r_i     <= CntW'(Entries - 1);
                                r_state <= ST_SCAN;
                            end
                            CMD_RESOLVE: begin
                                // Gateway lookups scan from the top entry down.
                                r_i     <= gate_c ? CntW'(Entries - 1) : '0;
                                r_state <= ST_SCAN;
                            end
                            default: begin
                                r_i     <= '0;
                                r_state <= ST_SCAN;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    unique case (r_cur.cmd)
                        CMD_LEARN: begin
                            // Match search and replacement choice in one pass.
                            if (!r_found && r_ip[ci] == r_cur.ip && (r_vld[ci] || r_gw[ci])) begin
                                r_found <= 1'b1;
                                r_fidx  <= ci;
                            end
                            if (!r_gw[ci] && !r_cand_ok) begin
                                if (!r_vld[ci]) begin
                                    r_cand    <= ci;
                                    r_cand_ok <= 1'b1;
                                end else if (ci == '0 || r_stamp[ci] < r_stamp[r_cand]) begin
                                    r_cand <= ci;
                                end
                            end
                            if (r_i == CntW'(Entries - 1)) r_state <= ST_DECIDE;
                            else r_i <= r_i + 1'b1;
                        end
                        CMD_RESOLVE: begin
                            if (!r_needgate) begin
                                if (r_ip[ci] == r_cur.ip && fresh_c) begin
                                    r_fidx  <= ci;
                                    r_found <= 1'b1;
                                    r_state <= ST_DECIDE;
                                end else if (r_i == CntW'(Entries - 1)) begin
                                    r_state <= ST_DECIDE;
                                end else r_i <= r_i + 1'b1;
                            end else begin
                                if (r_gw[ci]) r_any <= 1'b1;
                                if (r_gw[ci] && fresh_c) begin
                                    r_fidx  <= ci;
                                    r_found <= 1'b1;
                                    r_state <= ST_DECIDE;
                                end else if (r_i == '0) begin
                                    r_state <= ST_DECIDE;
                                end else r_i <= r_i - 1'b1;
                            end
                        end
                        default: begin
                            // Gateway slot search, top down to the half point.
                            if (!r_gw[ci]) begin
                                r_gw[ci]  <= 1'b1;
                                r_vld[ci] <= 1'b0;
                                r_ip[ci]  <= r_cur.ip;
                                r_fidx    <= ci;
                                r_kind    <= KIND_REQUEST;
                                r_oidx    <= '0;
                                r_ohw     <= '0;
                                r_orip    <= r_cur.ip;
                                r_olast   <= 1'b0;
                                r_found   <= 1'b1;
                                r_ret     <= ST_FINAL;
                                r_state   <= ST_OUT;
                            end else if (r_i == CntW'(Entries / 2)) begin
                                r_found <= 1'b0;
                                r_state <= ST_FINAL;
                            end else r_i <= r_i - 1'b1;
                        end
                    endcase
                end
                ST_DECIDE: begin
                    if (r_cur.cmd == CMD_LEARN) begin
                        r_ip[r_found ? r_fidx : r_cand]    <= r_cur.ip;
                        r_hw[r_found ? r_fidx : r_cand]    <= r_cur.hw;
                        r_stamp[r_found ? r_fidx : r_cand] <= r_tick;
                        r_vld[r_found ? r_fidx : r_cand]   <= 1'b1;
                        r_next_req <= 32'd0;
                        r_kind  <= KIND_LEARNED;
                        r_oidx  <= 5'(r_found ? r_fidx : r_cand);
                        r_ohw   <= '0;
                        r_orip  <= '0;
                        r_olast <= 1'b1;
                        r_ret   <= ST_IDLE;
                        r_state <= ST_OUT;
                    end else if (r_found) begin
                        r_kind  <= KIND_HIT;
                        r_oidx  <= 5'(r_fidx);
                        r_ohw   <= r_hw[r_fidx];
                        r_orip  <= '0;
                        r_olast <= 1'b1;
                        r_ret   <= ST_IDLE;
                        r_state <= ST_OUT;
                    end else if (r_tick >= r_next_req) begin
                        r_next_req <= hold_sum[32] ? 32'hFFFF_FFFF : hold_sum[31:0];
                        r_oidx     <= '0;
                        r_ohw      <= '0;
                        if (r_needgate && r_any) begin
                            r_i     <= CntW'(Entries - 1);
                            r_state <= ST_GWREQ;
                        end else begin
                            r_kind  <= KIND_REQUEST;
                            r_orip  <= r_cur.ip;
                            r_olast <= 1'b0;
                            r_ret   <= ST_FINAL;
                            r_state <= ST_OUT;
                        end
                    end else r_state <= ST_FINAL;
                end
                ST_GWREQ: begin
                    // One request per gateway entry, high index first.
                    if (r_gw[ci]) begin
                        r_kind  <= KIND_REQUEST;
                        r_orip  <= r_ip[ci];
                        r_olast <= 1'b0;
                        r_ret   <= (r_i == '0) ? ST_FINAL : ST_GWREQ;
                        r_state <= ST_OUT;
                    end else if (r_i == '0) r_state <= ST_FINAL;
                    if (r_i != '0) r_i <= r_i - 1'b1;
                end
                ST_FINAL: begin
                    r_oidx  <= (r_cur.cmd != CMD_RESOLVE && r_found) ? 5'(r_fidx) : '0;
                    r_ohw   <= '0;
                    r_orip  <= '0;
                    r_olast <= 1'b1;
                    if (r_cur.cmd == CMD_RESOLVE) r_kind <= KIND_MISS;
                    else if (r_found) r_kind <= KIND_GW_ADD;
                    else r_kind <= KIND_GW_FULL;
                    r_ret   <= ST_IDLE;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (i_ready) r_state <= r_ret;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/arp_cache_resolver.sv
// Top level of the address-resolution cache.
// Depends on acr_pkg, acr_front and acr_back.
`timescale 1ns / 1ps
// An 8-entry IP-to-hardware address cache. Commands enter a two-deep queue
// and a sequencer examines one cache entry per clock while no result transfer
// is stalled. A resolve gives up to five results and a tick none; a stalled
// result transfer holds the sequencer. The per-entry scan sets the rate.
// Configuration writes are taken at any time but should only be made while
// the block is idle.
module arp_cache_resolver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_target_ip,
    input  logic [47:0] i_hw_addr,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [4:0]  o_entry_index,
    output logic [47:0] o_hw_out,
    output logic [31:0] o_request_ip,
    output logic        o_last
);
    import acr_pkg::*;

    t_item       item;
    logic        item_valid, item_pop;
    logic [31:0] local_ip, net_mask;
    logic [23:0] lifetime;
    logic [15:0] holdoff;

    // Front part: transfers and queue.
    acr_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_command, .i_target_ip, .i_hw_addr,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_local_ip(local_ip), .o_net_mask(net_mask), .o_lifetime(lifetime),
        .o_holdoff(holdoff), .o_item(item), .o_item_valid(item_valid),
        .i_item_pop(item_pop)
    );

    // Back part: cache and result sequencer.
    acr_back u_back (
        .i_clk, .i_rst_n, .i_item(item), .i_item_valid(item_valid),
        .o_item_pop(item_pop), .i_local_ip(local_ip), .i_net_mask(net_mask),
        .i_lifetime(lifetime), .i_holdoff(holdoff), .o_valid, .i_ready, .o_kind,
        .o_entry_index, .o_hw_out, .o_request_ip, .o_last
    );
endmodule

>>> rtl/acr_checker.sv
// Port-level checker for the address-resolution cache, bound to the top.
// Depends on acr_pkg and arp_cache_resolver_assert.svh.
`timescale 1ns / 1ps
`include "arp_cache_resolver_assert.svh"
module acr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_kind,
    input logic [4:0]  o_entry_index,
    input logic [47:0] o_hw_out,
    input logic        o_last
);
    import acr_pkg::*;

    // A stalled result transfer holds its kind.
    `ACR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_kind), "result changed while stalled")
    // Requests are never the final result.
    `ACR_ASSERT_IMPL(a_req_not_last, i_clk, i_rst_n, o_valid && o_kind == KIND_REQUEST, !o_last, "request marked last")
    // Misses, hits and learns end a command.
    `ACR_ASSERT_IMPL(a_end_last, i_clk, i_rst_n, o_valid && (o_kind == KIND_MISS || o_kind == KIND_HIT || o_kind == KIND_LEARNED), o_last, "final result not marked last")
    // Only hits carry a hardware address.
    `ACR_ASSERT_IMPL(a_hw_hit, i_clk, i_rst_n, o_valid && o_kind != KIND_HIT, o_hw_out == 48'd0, "address on a non-hit")
    // Entry indices stay within the cache.
    `ACR_ASSERT_IMPL(a_idx, i_clk, i_rst_n, o_valid, o_entry_index < 5'(Entries), "entry index out of range")
endmodule

bind arp_cache_resolver acr_checker u_checker (.*);

>>> test/arp_cache_resolver_tb.sv
// Self-checking testbench for the address-resolution cache arp_cache_resolver.
// It depends on acr_pkg and the RTL. A built-in cache predictor checks every
// result transfer under random command streams, random stalls and register settings.
`timescale 1ns / 1ps
module arp_cache_resolver_tb;
    import acr_pkg::*;

    localparam int  NumSlots    = 8;
    localparam int  CycleLimit  = 400000;
    localparam int  SettleWait  = 40;

    // One expected or observed result transfer.
    typedef struct {
        t_kind       kind;
        logic [4:0]  index;
        logic [47:0] hw;
        logic [31:0] rip;
        logic        last;
    } t_res;

    // Cache predictor together with the queue of results still awaited.
    class cache_scoreboard;
        logic [31:0] ip_tab[NumSlots];
        logic [47:0] hw_tab[NumSlots];
        logic [31:0] stamp_tab[NumSlots];
        bit          gw_tab[NumSlots];
        bit          live_tab[NumSlots];
        logic [31:0] ticks, req_time;
        logic [31:0] my_ip, mask;
        logic [23:0] lifetime;
        logic [15:0] holdoff;
        t_res        awaited[$];
        int          errors, checked, hits, misses, requests;

        function new();
            for (int i = 0; i < NumSlots; i++) begin
                ip_tab[i] = 0; hw_tab[i] = 0; stamp_tab[i] = 0;
                gw_tab[i] = 0; live_tab[i] = 0;
            end
            ticks = 0; req_time = 0; my_ip = 0; mask = 32'hFFFF_FF00;
            lifetime = 24'd16384; holdoff = 16'd18;
            errors = 0; checked = 0; hits = 0; misses = 0; requests = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_LOCAL_IP: my_ip = data;
                REG_NET_MASK: mask = data;
                REG_LIFETIME: lifetime = data[23:0];
                default:      holdoff = data[15:0];
            endcase
        endfunction

        function bit is_fresh(int i);
            longint unsigned lim;
            lim = longint'(stamp_tab[i]) + longint'(lifetime);
            return live_tab[i] && (lim > longint'(ticks));
        endfunction

        function void push(t_kind k, int idx, logic [47:0] h, logic [31:0] r, bit l);
            t_res e;
            e.kind = k; e.index = idx[4:0]; e.hw = h; e.rip = r; e.last = l;
            awaited.push_back(e);
        endfunction

        function void arm_holdoff();
            longint unsigned t;
            t = longint'(ticks) + longint'(holdoff);
            req_time = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        endfunction

        // Works out the results of one accepted command and updates the state.
        function void note_command(t_cmd cmd, logic [31:0] ip, logic [47:0] hw);
            int  slot;
            bit  any;
            slot = -1;
            any = 0;
            case (cmd)
                CMD_LEARN: begin
                    for (int i = 0; i < NumSlots; i++)
                        if (slot < 0 && ip_tab[i] == ip && (live_tab[i] || gw_tab[i]))
                            slot = i;
                    if (slot < 0) begin
                        // Empty plain slots first, then the oldest stamp.
                        slot = 0;
                        for (int i = 1; i < NumSlots; i++) begin
                            if (gw_tab[i]) continue;
                            if (!live_tab[slot]) break;
                            if (!live_tab[i] || stamp_tab[i] < stamp_tab[slot]) slot = i;
                        end
                    end
                    ip_tab[slot] = ip; hw_tab[slot] = hw; stamp_tab[slot] = ticks;
                    live_tab[slot] = 1; req_time = 0;
                    push(KIND_LEARNED, slot, 0, 0, 1);
                end
                CMD_RESOLVE: begin
                    if (((ip ^ my_ip) & mask) == 0) begin
                        for (int i = 0; i < NumSlots; i++)
                            if (slot < 0 && ip_tab[i] == ip && is_fresh(i)) slot = i;
                        if (slot < 0 && ticks >= req_time) begin
                            push(KIND_REQUEST, 0, 0, ip, 0);
                            requests++;
                            arm_holdoff();
                        end
                    end else begin
                        for (int i = NumSlots - 1; i >= 0; i--)
                            if (slot < 0 && gw_tab[i] && is_fresh(i)) slot = i;
                        if (slot < 0 && ticks >= req_time) begin
                            for (int i = NumSlots - 1; i >= 0; i--)
                                if (gw_tab[i]) begin
                                    any = 1;
                                    push(KIND_REQUEST, 0, 0, ip_tab[i], 0);
                                    requests++;
                                end
                            if (!any) begin
                                push(KIND_REQUEST, 0, 0, ip, 0);
                                requests++;
                            end
                            arm_holdoff();
                        end
                    end
                    if (slot >= 0) begin
                        push(KIND_HIT, slot, hw_tab[slot], 0, 1);
                        hits++;
                    end else begin
                        push(KIND_MISS, 0, 0, 0, 1);
                        misses++;
                    end
                end
                CMD_GATEWAY: begin
                    for (int i = NumSlots - 1; i >= NumSlots / 2; i--)
                        if (slot < 0 && !gw_tab[i]) slot = i;
                    if (slot >= 0) begin
                        gw_tab[slot] = 1; ip_tab[slot] = ip; live_tab[slot] = 0;
                        push(KIND_REQUEST, 0, 0, ip, 0);
                        push(KIND_GW_ADD, slot, 0, 0, 1);
                    end else begin
                        push(KIND_GW_FULL, 0, 0, 0, 1);
                    end
                end
                default: if (ticks != 32'hFFFF_FFFF) ticks++;
            endcase
        endfunction

        // Compares one result transfer with the oldest expectation.
        function void check_result(t_res got);
            t_res e;
            checked++;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: result kind %0d with none expected",
                                           got.kind);
                return;
            end
            e = awaited.pop_front();
            if (got.kind !== e.kind || got.index !== e.index || got.hw !== e.hw ||
                got.rip !== e.rip || got.last !== e.last) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: expected kind %0d idx %0d hw %h ip %h last %0d, got %0d %0d %h %h %0d",
                             e.kind, e.index, e.hw, e.rip, e.last,
                             got.kind, got.index, got.hw, got.rip, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_command = 0;
    logic [31:0] i_target_ip = 0;
    logic [47:0] i_hw_addr = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [2:0]  o_kind;
    logic [4:0]  o_entry_index;
    logic [47:0] o_hw_out;
    logic [31:0] o_request_ip;
    logic        o_last;

    cache_scoreboard sb = new();
    int cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int sent = 0;

    arp_cache_resolver uut (.*);

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("TIMEOUT after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge i_clk)
        i_ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall);

    // Every result transfer is checked on the rising edge.
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && o_valid && i_ready) begin
            got.kind = t_kind'(o_kind); got.index = o_entry_index; got.hw = o_hw_out;
            got.rip = o_request_ip; got.last = o_last;
            sb.check_result(got);
        end
    end

    // Offers one command and returns once its transfer has been taken.
    task automatic send_command(t_cmd cmd, logic [31:0] ip, logic [47:0] hw);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle) begin
            i_valid = 0;
            @(negedge i_clk);
        end
        i_valid = 1; i_command = cmd; i_target_ip = ip; i_hw_addr = hw;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        sb.note_command(cmd, ip, hw);
        sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_valid = 0;
        i_cfg_valid = 1; i_cfg_index = idx; i_cfg_data = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    // Waits until every awaited result has arrived and the block has settled.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SettleWait) @(posedge i_clk);
    endtask

    task automatic load_setting(logic [31:0] lip, logic [31:0] msk, logic [23:0] life,
                                logic [15:0] hold);
        drain();
        write_reg(REG_LOCAL_IP, lip);
        write_reg(REG_NET_MASK, msk);
        write_reg(REG_LIFETIME, {8'd0, life});
        write_reg(REG_HOLDOFF, {16'd0, hold});
    endtask

    function automatic logic [31:0] pick_ip();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return {sb.my_ip[31:8], 5'd0, 3'($urandom_range(0, 7))};
        if (r < 75) return 32'h0800_0000 + $urandom_range(0, 3);
        return $urandom;
    endfunction

    // Random commands with idling and back-pressure chosen from the overall command count.
    task automatic random_commands(int count);
        int    r;
        t_cmd  cmd;
        for (int n = 0; n < count; n++) begin
            if (sent < 90)       begin send_idle = 24; recv_stall = 52; end
            else if (sent < 160) begin send_idle = 52; recv_stall = 24; end
            else                 begin send_idle = 0;  recv_stall = 0;  end
            r = $urandom_range(0, 99);
            cmd = (r < 30) ? CMD_LEARN : (r < 65) ? CMD_RESOLVE :
                  (r < 72) ? CMD_GATEWAY : CMD_TICK;
            send_command(cmd, pick_ip(), {16'($urandom), 32'($urandom)});
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed part with reset register values.
        send_command(CMD_LEARN, 32'h0000_0005, 48'hFFFF_FFFF_FFFF);
        send_command(CMD_RESOLVE, 32'h0000_0005, 0);
        send_command(CMD_RESOLVE, 32'h0000_0009, 0);
        send_command(CMD_RESOLVE, 32'h0000_000A, 0);
        send_command(CMD_TICK, 0, 0);
        send_command(CMD_RESOLVE, 32'hFFFF_FFFF, 0);
        for (int g = 0; g < 4; g++) send_command(CMD_GATEWAY, 32'h0800_0000 + g, 0);
        send_command(CMD_GATEWAY, 32'h0800_0001, 0);
        send_command(CMD_RESOLVE, 32'h4000_0000, 48'hFFFF_FFFF_FFFF);
        send_command(CMD_LEARN, 32'h0800_0002, 48'h0000_0000_0000);
        send_command(CMD_RESOLVE, 32'h4000_0000, 0);
        for (int k = 0; k < 6; k++)
            send_command(CMD_LEARN, 32'h0000_0010 + k, 48'h1234_0000_0000 + k);
        send_command(CMD_TICK, 0, 0);
        send_command(CMD_LEARN, 32'hFFFF_FFFF, 48'hA5A5_5A5A_0F0F);
        send_command(CMD_LEARN, 32'h0000_0000, 48'h0);
        send_command(CMD_RESOLVE, 32'h0000_0000, 0);

        // Random part over several register settings, extremes included.
        load_setting(32'h0000_0001, 32'hFFFF_FF00, 24'd6, 16'd3);
        random_commands(50);
        load_setting(32'hC0A8_0010, 32'h0000_0000, 24'hFF_FFFF, 16'hFFFF);
        random_commands(50);
        load_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd1, 16'd1);
        random_commands(50);
        load_setting(32'h0000_0001, 32'hFFFF_0000, 24'd0, 16'd2);
        random_commands(50);
        drain();

        $display("Run covered %0d commands, %0d results: %0d hits, %0d misses, %0d requests.",
                 sent, sb.checked, sb.hits, sb.misses, sb.requests);
        $display("Mismatches counted: %0d", sb.errors);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/acr_pkg.sv
rtl/acr_front.sv
rtl/acr_back.sv
rtl/arp_cache_resolver.sv
rtl/acr_checker.sv
test/arp_cache_resolver_tb.sv
